// ----- design/sttq_pkg.sv -----
// Shared types, codes and constants for the sorted timer queue.
package sttq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned MAX_EXPIRE_DEF = 16;

  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [31:0] LATE_LIMIT = 32'hFFFF_F000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_EXPIRE = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [7:0]  id;
    logic        per;
    logic [31:0] period;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    logic        earlier;
    logic        late;
  } alu_flags_t;

endpackage

// ----- design/sttq_alu.sv -----
// Shared 32-bit add/subtract unit with wrap-aware order and expiry flags.
module sttq_alu
  import sttq_pkg::*;
(
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res,
  output alu_flags_t  flags
);

  always_comb begin
    res = (op == ALU_ADD) ? (a + b) : (a - b);
    flags.earlier = (res > HALF_RANGE);
    flags.late    = (res >= LATE_LIMIT);
  end

endmodule

// ----- design/sttq_mem.sv -----
// Timer entry store: one write port, one registered read port.
module sttq_mem
  import sttq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/sorted_timer_queue.sv -----
// Top level: sequencer for the sorted timer queue.
//
//  port group  dir  handshake             payload
//  in_*        in   start && !busy        in_cmd, in_timer_id, in_periodic,
//                                         in_timeout_ms, in_now_ms
//  out_*       out  out_valid, 1 cycle    out_kind, out_id, out_running,
//                                         out_dropped, out_last
//
// One word at a time; busy stays high until all its results are out.
// Scans and shifts go through the entry store one entry at a time, with a
// read state and then a check or write state for each; a query scans the
// held entries, an add scans and shifts them, and a tick does so again per
// expired entry; the single read port and the shared adder set this pace.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_timer_queue
  import sttq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned MAX_EXPIRE = MAX_EXPIRE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_timer_id,
  input  logic        in_periodic,
  input  logic [31:0] in_timeout_ms,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_id,
  output logic        out_running,
  output logic        out_dropped,
  output logic        out_last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_EXPIRE + 1);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_FIND_RD  = 16'h0002,
    S_FIND_CK  = 16'h0004,
    S_FDONE    = 16'h0008,
    S_DROP_RD  = 16'h0010,
    S_DROP_WR  = 16'h0020,
    S_DROPPED  = 16'h0040,
    S_ADDSUM   = 16'h0080,
    S_PSCAN_RD = 16'h0100,
    S_PSCAN_CK = 16'h0200,
    S_SHIFT_RD = 16'h0400,
    S_SHIFT_WR = 16'h0800,
    S_PLACED   = 16'h1000,
    S_TICK_RD  = 16'h2000,
    S_TICK_CK  = 16'h4000,
    S_REARM    = 16'h8000
  } state_t;

  state_t          state_r, state_nxt;
  cmd_t            cmd_r;
  logic [31:0]     now_r;
  entry_t          ent_r, ent_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            found_r, found_nxt;
  logic [NW-1:0]   nexp_r, nexp_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      pend_id_r, pend_id_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  entry_t          wdata, rdata;

  alu_op_t         alu_op;
  logic [31:0]     alu_a, alu_b, alu_res;
  alu_flags_t      alu_flags;

  logic            emit_v;
  kind_t           emit_kind;
  logic [7:0]      emit_id;
  logic            emit_run, emit_drop, emit_last;

  logic            accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  sttq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sttq_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    nexp_nxt    = nexp_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    we          = 1'b0;
    waddr       = idx_r[AW-1:0];
    wdata       = rdata;
    raddr       = idx_r[AW-1:0];
    alu_op      = ALU_SUB;
    alu_a       = rdata.deadline;
    alu_b       = ent_r.deadline;
    emit_v      = 1'b0;
    emit_kind   = KIND_EXPIRE;
    emit_id     = ent_r.id;
    emit_run    = 1'b0;
    emit_drop   = 1'b0;
    emit_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ent_nxt.id       = in_timer_id;
          ent_nxt.per      = in_periodic;
          ent_nxt.period   = in_timeout_ms;
          ent_nxt.deadline = in_timeout_ms;
          idx_nxt          = '0;
          found_nxt        = 1'b0;
          nexp_nxt         = '0;
          pend_nxt         = 1'b0;
          state_nxt = (cmd_t'(in_cmd) == CMD_TICK) ? S_TICK_RD : S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        state_nxt = (idx_r == cnt_r) ? S_FDONE : S_FIND_CK;
      end
      S_FIND_CK: begin
        if (rdata.id == ent_r.id) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
          state_nxt = S_FDONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end
      S_FDONE: begin
        if (cmd_r == CMD_QUERY) begin
          emit_v    = 1'b1;
          emit_kind = KIND_QUERY;
          emit_run  = found_r;
          state_nxt = S_IDLE;
        end else if (found_r) begin
          idx_nxt   = pos_r;
          state_nxt = S_DROP_RD;
        end else begin
          state_nxt = S_DROPPED;
        end
      end
      // close the gap: entry i takes entry i+1
      S_DROP_RD: begin
        raddr = AW'(idx_r + 1'b1);
        if (CW'(idx_r + 1'b1) >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DROPPED;
        end else begin
          state_nxt = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DROP_RD;
      end
      S_DROPPED: begin
        unique case (cmd_r)
          CMD_CANCEL: begin
            emit_v    = 1'b1;
            emit_kind = KIND_CANCEL;
            state_nxt = S_IDLE;
          end
          CMD_ADD: begin
            if (cnt_r == CW'(DEPTH)) begin
              emit_v    = 1'b1;
              emit_kind = KIND_ADD;
              emit_drop = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_ADDSUM;
            end
          end
          default: state_nxt = S_REARM;
        endcase
      end
      S_ADDSUM: begin
        alu_op           = ALU_ADD;
        alu_a            = now_r;
        alu_b            = ent_r.period;
        ent_nxt.deadline = alu_res;
        idx_nxt          = '0;
        state_nxt        = S_PSCAN_RD;
      end
      S_PSCAN_RD: begin
        if (idx_r == cnt_r) begin
          pos_nxt   = idx_r;
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_PSCAN_CK;
        end
      end
      S_PSCAN_CK: begin
        if (alu_flags.earlier) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PSCAN_RD;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = cnt_r;
          state_nxt = S_SHIFT_RD;
        end
      end
      // open a gap at pos: entry i takes entry i-1, from the tail down
      S_SHIFT_RD: begin
        raddr = AW'(idx_r - 1'b1);
        if (idx_r == pos_r) begin
          we        = 1'b1;
          waddr     = pos_r[AW-1:0];
          wdata     = ent_r;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PLACED;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      S_PLACED: begin
        if (cmd_r == CMD_ADD) begin
          emit_v    = 1'b1;
          emit_kind = KIND_ADD;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TICK_RD;
        end
      end
      S_TICK_RD: begin
        raddr = '0;
        if (nexp_r == NW'(MAX_EXPIRE) || cnt_r == '0) begin
          emit_v    = pend_r;
          emit_id   = pend_id_r;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TICK_CK;
        end
      end
      S_TICK_CK: begin
        alu_b = now_r;
        if (alu_flags.late) begin
          // previous expiry is now known not to be the final word
          emit_v      = pend_r;
          emit_id     = pend_id_r;
          emit_last   = 1'b0;
          pend_nxt    = 1'b1;
          pend_id_nxt = rdata.id;
          ent_nxt     = rdata;
          nexp_nxt    = nexp_r + 1'b1;
          idx_nxt     = '0;
          state_nxt   = S_DROP_RD;
        end else begin
          emit_v    = pend_r;
          emit_id   = pend_id_r;
          state_nxt = S_IDLE;
        end
      end
      S_REARM: begin
        alu_op           = ALU_ADD;
        alu_a            = ent_r.deadline;
        alu_b            = ent_r.period;
        ent_nxt.deadline = alu_res;
        idx_nxt          = '0;
        state_nxt        = ent_r.per ? S_PSCAN_RD : S_TICK_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= emit_v;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      now_r <= in_now_ms;
    end
    ent_r       <= ent_nxt;
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    found_r     <= found_nxt;
    nexp_r      <= nexp_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind    <= emit_kind;
    out_id      <= emit_id;
    out_running <= emit_run;
    out_dropped <= emit_drop;
    out_last    <= emit_last;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("entry count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted word did not make block busy");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results on back-to-back cycles");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_EXPIRE) |-> out_last)
    else $error("ack not flagged last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after final result");

endmodule
